FILE: rtl/plep_pkg.sv
package plep_pkg;

  localparam int unsigned MaxPayload = 640;

  localparam int unsigned JobDepth = 2;
  localparam int unsigned JobPtrW  = (JobDepth > 1) ? $clog2(JobDepth) : 1;
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);

  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] PktLastPrint = 4'd13;
  localparam logic [IdxW-1:0] PktLastShort = 4'd9;
  localparam logic [IdxW-1:0] PktLastOpen  = 4'd5;
  localparam logic [IdxW-1:0] PayLastTail  = 4'd4;

  localparam logic [7:0]  MagicLo    = 8'h88;
  localparam logic [7:0]  MagicHi    = 8'h33;
  localparam logic [7:0]  Sheets     = 8'h01;
  localparam logic [7:0]  Palette    = 8'hE4;
  localparam logic [7:0]  AckGood    = 8'h80;
  localparam logic [7:0]  AckAlt     = 8'h81;
  localparam logic [7:0]  FeedMax    = 8'h0F;
  localparam logic [7:0]  DensMax    = 8'h7F;
  localparam logic [15:0] PrintLen   = 16'h0004;

  localparam logic [7:0] CodeInit    = 8'h01;
  localparam logic [7:0] CodePrint   = 8'h02;
  localparam logic [7:0] CodeData    = 8'h04;
  localparam logic [7:0] CodeBreak   = 8'h08;
  localparam logic [7:0] CodeInquiry = 8'h0F;

  localparam logic [7:0] FatalMaskRst = 8'hF1;
  localparam logic [7:0] BusyMaskRst  = 8'h02;

  localparam logic CfgFatalMask = 1'b0;
  localparam logic CfgBusyMask  = 1'b1;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_REPLY   = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CMD_INIT     = 3'd0,
    CMD_PRINT    = 3'd1,
    CMD_DATA     = 3'd2,
    CMD_DATA_END = 3'd3,
    CMD_BREAK    = 3'd4,
    CMD_INQUIRY  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_REPLY   = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    OP_PKT  = 3'b001,
    OP_PAY  = 3'b010,
    OP_VERD = 3'b100
  } job_op_e;

  typedef struct packed {
    job_op_e     op;
    logic [7:0]  code;
    logic [15:0] len;
    logic        is_print;
    logic        tail;
    logic [15:0] ck;
    logic [7:0]  feeds;
    logic [7:0]  dens;
    logic [7:0]  data;
    logic        ok;
    logic        ack_valid;
    logic        fatal;
    logic        busy;
    logic [7:0]  status;
  } job_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic       ok;
    logic       ack_valid;
    logic       fatal;
    logic       busy;
    logic [7:0] status;
  } res_t;

  function automatic logic [7:0] cmd_code(input cmd_e cmd);
    logic [7:0] code;
    case (cmd)
      CMD_INIT:     code = CodeInit;
      CMD_PRINT:    code = CodePrint;
      CMD_DATA:     code = CodeData;
      CMD_DATA_END: code = CodeData;
      CMD_BREAK:    code = CodeBreak;
      CMD_INQUIRY:  code = CodeInquiry;
      default:      code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/plep_front.sv
module plep_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  input  logic          take_i,
  input  logic [1:0]    mode_i,
  input  logic [2:0]    command_i,
  input  logic [15:0]   payload_length_i,
  input  logic [7:0]    before_feeds_i,
  input  logic [7:0]    after_feeds_i,
  input  logic [7:0]    density_i,
  input  logic [7:0]    data_byte_i,
  input  logic [7:0]    reply_ack_i,
  input  logic [7:0]    reply_status_i,
  output logic          job_push_o,
  output plep_pkg::job_t job_o
);
  import plep_pkg::*;

  logic [7:0]  fatal_mask_q, busy_mask_q;
  cmd_e        cmd_q, cmd_d;
  logic [15:0] ck_q, ck_d;
  logic [15:0] left_q, left_d;
  phase_e      phase_q, phase_d;

  cmd_e        cmd;
  logic        is_print, is_data, oversize, open_data;
  logic [3:0]  bf, af;
  logic [7:0]  feeds, dens, code;
  logic [15:0] len_w, start_ck, pay_ck;
  logic        ackv, fat, busy, ok;

  always_comb begin
    cmd       = cmd_e'(command_i);
    code      = cmd_code(cmd);
    is_print  = (cmd == CMD_PRINT);
    is_data   = (cmd == CMD_DATA);
    bf        = (before_feeds_i > FeedMax) ? FeedMax[3:0] : before_feeds_i[3:0];
    af        = (after_feeds_i > FeedMax) ? FeedMax[3:0] : after_feeds_i[3:0];
    feeds     = {bf, af};
    dens      = (density_i > DensMax) ? DensMax : density_i;
    len_w     = is_print ? PrintLen : (is_data ? payload_length_i : 16'h0000);
    oversize  = is_data && (payload_length_i > 16'(MaxPayload));
    open_data = is_data && (payload_length_i != 16'h0000);
    start_ck  = {8'h00, code} + {8'h00, len_w[7:0]} + {8'h00, len_w[15:8]};
    if (is_print) begin
      start_ck = start_ck + {8'h00, Sheets} + {8'h00, feeds} + {8'h00, Palette}
                 + {8'h00, dens};
    end
    pay_ck = ck_q + {8'h00, data_byte_i};
    ackv   = (reply_ack_i == AckGood) || (reply_ack_i == AckAlt);
    fat    = (reply_status_i & fatal_mask_q) != 8'h00;
    busy   = (reply_status_i & busy_mask_q) != 8'h00;
    case (cmd_q)
      CMD_INIT:  ok = ackv && (reply_status_i == 8'h00);
      CMD_PRINT: ok = ackv && !fat && !busy;
      default:   ok = ackv && !fat;
    endcase
  end

  always_comb begin
    cmd_d      = cmd_q;
    ck_d       = ck_q;
    left_d     = left_q;
    phase_d    = phase_q;
    job_push_o = 1'b0;
    job_o      = '0;
    job_o.op   = OP_PKT;
    if (take_i) begin
      case (mode_e'(mode_i))
        MODE_START: begin
          if (command_i <= 3'(CMD_INQUIRY)) begin
            cmd_d      = cmd;
            left_d     = '0;
            job_push_o = 1'b1;
            if (oversize) begin
              ck_d     = '0;
              phase_d  = PH_IDLE;
              job_o.op = OP_VERD;
            end else begin
              ck_d           = start_ck;
              job_o.op       = OP_PKT;
              job_o.code     = code;
              job_o.len      = len_w;
              job_o.is_print = is_print;
              job_o.tail     = !open_data;
              job_o.ck       = start_ck;
              job_o.feeds    = feeds;
              job_o.dens     = dens;
              if (open_data) begin
                phase_d = PH_PAYLOAD;
                left_d  = payload_length_i;
              end else begin
                phase_d = PH_REPLY;
              end
            end
          end
        end
        MODE_PAYLOAD: begin
          if (phase_q == PH_PAYLOAD) begin
            job_push_o = 1'b1;
            ck_d       = pay_ck;
            left_d     = left_q - 16'd1;
            job_o.op   = OP_PAY;
            job_o.data = data_byte_i;
            job_o.ck   = pay_ck;
            job_o.tail = (left_q == 16'd1);
            if (left_q == 16'd1) begin
              phase_d = PH_REPLY;
            end
          end
        end
        MODE_REPLY: begin
          if (phase_q == PH_REPLY) begin
            job_push_o      = 1'b1;
            phase_d         = PH_IDLE;
            job_o.op        = OP_VERD;
            job_o.ok        = ok;
            job_o.ack_valid = ackv;
            job_o.fatal     = fat;
            job_o.busy      = busy;
            job_o.status    = reply_status_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fatal_mask_q <= FatalMaskRst;
      busy_mask_q  <= BusyMaskRst;
      cmd_q        <= CMD_INIT;
      ck_q         <= '0;
      left_q       <= '0;
      phase_q      <= PH_IDLE;
    end else begin
      cmd_q   <= cmd_d;
      ck_q    <= ck_d;
      left_q  <= left_d;
      phase_q <= phase_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFatalMask: fatal_mask_q <= cfg_data_i;
          CfgBusyMask:  busy_mask_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/plep_job_fifo.sv
module plep_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  plep_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output plep_pkg::job_t data_o,
  output logic           empty_o
);
  import plep_pkg::*;

  job_t               slot_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == JobCntW'(JobDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/plep_back.sv
module plep_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  plep_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           res_pop_i,
  output logic           res_valid_o,
  output plep_pkg::res_t res_o
);
  import plep_pkg::*;

  logic [IdxW-1:0] idx_q;
  logic            res_valid_q;
  res_t            res_q, res_d;
  logic            advance, last;
  logic [7:0]      pkt_byte, pay_byte;
  logic [IdxW-1:0] last_idx;

  always_comb begin
    case (idx_q)
      4'd0:    pkt_byte = MagicLo;
      4'd1:    pkt_byte = MagicHi;
      4'd2:    pkt_byte = job_i.code;
      4'd3:    pkt_byte = 8'h00;
      4'd4:    pkt_byte = job_i.len[7:0];
      4'd5:    pkt_byte = job_i.len[15:8];
      4'd6:    pkt_byte = job_i.is_print ? Sheets : job_i.ck[7:0];
      4'd7:    pkt_byte = job_i.is_print ? job_i.feeds : job_i.ck[15:8];
      4'd8:    pkt_byte = job_i.is_print ? Palette : 8'h00;
      4'd9:    pkt_byte = job_i.is_print ? job_i.dens : 8'h00;
      4'd10:   pkt_byte = job_i.ck[7:0];
      4'd11:   pkt_byte = job_i.ck[15:8];
      default: pkt_byte = 8'h00;
    endcase
    case (idx_q)
      4'd0:    pay_byte = job_i.data;
      4'd1:    pay_byte = job_i.ck[7:0];
      4'd2:    pay_byte = job_i.ck[15:8];
      default: pay_byte = 8'h00;
    endcase
    if (job_i.is_print) begin
      last_idx = PktLastPrint;
    end else if (job_i.tail) begin
      last_idx = PktLastShort;
    end else begin
      last_idx = PktLastOpen;
    end

    res_d = '0;
    case (job_i.op)
      OP_PKT: begin
        last          = (idx_q == last_idx);
        res_d.tx_byte = pkt_byte;
      end
      OP_PAY: begin
        last          = job_i.tail ? (idx_q == PayLastTail) : 1'b1;
        res_d.tx_byte = pay_byte;
      end
      default: begin
        last            = 1'b1;
        res_d.kind      = 1'b1;
        res_d.ok        = job_i.ok;
        res_d.ack_valid = job_i.ack_valid;
        res_d.fatal     = job_i.fatal;
        res_d.busy      = job_i.busy;
        res_d.status    = job_i.status;
      end
    endcase
    res_d.last = last;
  end

  assign advance     = job_valid_i && (!res_valid_q || res_pop_i);
  assign job_pop_o   = advance && last;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        idx_q       <= last ? '0 : idx_q + 1'b1;
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/printer_link_packet_engine_top.sv
// Channel   Direction  Handshake          Transfer when
// input     in         push / full        push high and full low
// result    out        empty / pop        pop high and empty low
// config    in         cfg_we_i           cfg_we_i high
//
// The front part takes one input item per cycle while its two-entry job queue
// has room. The back part, unless a stalled result holds it, emits one result
// per cycle from the job at the queue head: a print start gives 14 results,
// init, break, inquiry, data end and an empty data start 10, an open data
// start 6, a payload item 1 or 5, a reply or an oversized data start 1. Reset
// clears the phase, the queue and the result valid flag and loads the mask
// resets. The front keeps accepting during a stall until the queue fills.
module printer_link_packet_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  command_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  before_feeds_i,
  input  logic [7:0]  after_feeds_i,
  input  logic [7:0]  density_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  reply_ack_i,
  input  logic [7:0]  reply_status_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        ok_o,
  output logic        ack_valid_o,
  output logic        fatal_o,
  output logic        busy_res_o,
  output logic [7:0]  status_byte_o
);
  import plep_pkg::*;

  logic take, job_push, job_pop, job_empty, res_valid;
  job_t job_in, job_head;
  res_t res;

  assign take = push && !full;

  plep_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .take_i           (take),
    .mode_i           (mode_i),
    .command_i        (command_i),
    .payload_length_i (payload_length_i),
    .before_feeds_i   (before_feeds_i),
    .after_feeds_i    (after_feeds_i),
    .density_i        (density_i),
    .data_byte_i      (data_byte_i),
    .reply_ack_i      (reply_ack_i),
    .reply_status_i   (reply_status_i),
    .job_push_o       (job_push),
    .job_o            (job_in)
  );

  plep_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .empty_o (job_empty)
  );

  plep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty         = !res_valid;
  assign kind_o        = res.kind;
  assign tx_byte_o     = res.tx_byte;
  assign last_o        = res.last;
  assign ok_o          = res.ok;
  assign ack_valid_o   = res.ack_valid;
  assign fatal_o       = res.fatal;
  assign busy_res_o    = res.busy;
  assign status_byte_o = res.status;

endmodule

FILE: bench/printer_link_packet_engine_top_tb.sv
module printer_link_packet_engine_top_tb;
  import plep_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned LongHold = 400;
  localparam logic [2:0] CmdSpareA = 3'd6;
  localparam logic [2:0] CmdSpareB = 3'd7;
  localparam logic KindByte = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef enum {
    LINK_IDLE,
    LINK_BODY,
    LINK_REPLY
  } link_phase_e;

  typedef struct {
    mode_e      mode;
    logic [2:0] command;
    logic [15:0] payload_length;
    logic [7:0] before_feeds;
    logic [7:0] after_feeds;
    logic [7:0] density;
    logic [7:0] data_byte;
    logic [7:0] reply_ack;
    logic [7:0] reply_status;
  } link_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode_i = 2'd0;
  logic [2:0]  command_i = 3'd0;
  logic [15:0] payload_length_i = 16'h0000;
  logic [7:0]  before_feeds_i = 8'h00;
  logic [7:0]  after_feeds_i = 8'h00;
  logic [7:0]  density_i = 8'h00;
  logic [7:0]  data_byte_i = 8'h00;
  logic [7:0]  reply_ack_i = 8'h00;
  logic [7:0]  reply_status_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        ok_o;
  logic        ack_valid_o;
  logic        fatal_o;
  logic        busy_res_o;
  logic [7:0]  status_byte_o;

  link_item_t  link_items_pending[$];
  res_t        link_results_due[$];

  logic [7:0]  fatal_bits = FatalMaskRst;
  logic [7:0]  busy_bits = BusyMaskRst;
  logic [2:0]  pkt_cmd = CMD_INIT;
  logic [15:0] pkt_sum = 16'h0000;
  logic [15:0] body_left = 16'h0000;
  link_phase_e link_phase = LINK_IDLE;

  int unsigned tx_idle_pct = 20;
  int unsigned rx_idle_pct = 87;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  printer_link_packet_engine_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .command_i        (command_i),
    .payload_length_i (payload_length_i),
    .before_feeds_i   (before_feeds_i),
    .after_feeds_i    (after_feeds_i),
    .density_i        (density_i),
    .data_byte_i      (data_byte_i),
    .reply_ack_i      (reply_ack_i),
    .reply_status_i   (reply_status_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .tx_byte_o        (tx_byte_o),
    .last_o           (last_o),
    .ok_o             (ok_o),
    .ack_valid_o      (ack_valid_o),
    .fatal_o          (fatal_o),
    .busy_res_o       (busy_res_o),
    .status_byte_o    (status_byte_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic link_item_t make_item(input mode_e m);
    link_item_t it;
    it.mode = m;
    it.command = 3'($urandom);
    it.payload_length = 16'($urandom);
    it.before_feeds = 8'($urandom);
    it.after_feeds = 8'($urandom);
    it.density = 8'($urandom);
    it.data_byte = 8'($urandom);
    it.reply_ack = 8'($urandom);
    it.reply_status = 8'($urandom);
    return it;
  endfunction

  function automatic link_item_t start_pkt(input logic [2:0] cmd, input logic [15:0] len);
    link_item_t it;
    it = make_item(MODE_START);
    it.command = cmd;
    it.payload_length = len;
    return it;
  endfunction

  function automatic link_item_t body_byte(input logic [7:0] b);
    link_item_t it;
    it = make_item(MODE_PAYLOAD);
    it.data_byte = b;
    return it;
  endfunction

  function automatic link_item_t printer_reply(input logic [7:0] ack, input logic [7:0] st);
    link_item_t it;
    it = make_item(MODE_REPLY);
    it.reply_ack = ack;
    it.reply_status = st;
    return it;
  endfunction

  task automatic put_wire_byte(input logic [7:0] b, input bit summed);
    res_t r;
    r = '0;
    r.kind = KindByte;
    r.tx_byte = b;
    link_results_due.push_back(r);
    if (summed) pkt_sum = pkt_sum + 16'(b);
  endtask

  task automatic put_packet_tail();
    put_wire_byte(pkt_sum[7:0], 1'b0);
    put_wire_byte(pkt_sum[15:8], 1'b0);
    put_wire_byte(8'h00, 1'b0);
    put_wire_byte(8'h00, 1'b0);
    link_phase = LINK_REPLY;
  endtask

  task automatic compute_link_results(input link_item_t item);
    int unsigned n_before;
    logic [7:0] code, bf, af, dens;
    logic ackv, fat, busy, ok;
    res_t r;
    n_before = link_results_due.size();
    case (item.mode)
      MODE_START: begin
        if (item.command <= CMD_INQUIRY) begin
          pkt_cmd = item.command;
          pkt_sum = 16'h0000;
          body_left = 16'h0000;
          if (item.command == CMD_DATA && 32'(item.payload_length) > MaxPayload) begin
            link_phase = LINK_IDLE;
            r = '0;
            r.kind = KindVerdict;
            link_results_due.push_back(r);
          end else begin
            case (item.command)
              CMD_INIT:                code = CodeInit;
              CMD_PRINT:               code = CodePrint;
              CMD_DATA, CMD_DATA_END:  code = CodeData;
              CMD_BREAK:               code = CodeBreak;
              default:                 code = CodeInquiry;
            endcase
            put_wire_byte(MagicLo, 1'b0);
            put_wire_byte(MagicHi, 1'b0);
            put_wire_byte(code, 1'b1);
            put_wire_byte(8'h00, 1'b0);
            if (item.command == CMD_PRINT) begin
              bf = (item.before_feeds > FeedMax) ? FeedMax : item.before_feeds;
              af = (item.after_feeds > FeedMax) ? FeedMax : item.after_feeds;
              dens = (item.density > DensMax) ? DensMax : item.density;
              put_wire_byte(PrintLen[7:0], 1'b1);
              put_wire_byte(PrintLen[15:8], 1'b1);
              put_wire_byte(Sheets, 1'b1);
              put_wire_byte({bf[3:0], af[3:0]}, 1'b1);
              put_wire_byte(Palette, 1'b1);
              put_wire_byte(dens, 1'b1);
              put_packet_tail();
            end else if (item.command == CMD_DATA) begin
              put_wire_byte(item.payload_length[7:0], 1'b1);
              put_wire_byte(item.payload_length[15:8], 1'b1);
              if (item.payload_length == 16'h0000) begin
                put_packet_tail();
              end else begin
                body_left = item.payload_length;
                link_phase = LINK_BODY;
              end
            end else begin
              put_wire_byte(8'h00, 1'b1);
              put_wire_byte(8'h00, 1'b1);
              put_packet_tail();
            end
          end
        end
      end
      MODE_PAYLOAD: begin
        if (link_phase == LINK_BODY) begin
          put_wire_byte(item.data_byte, 1'b1);
          body_left = body_left - 16'h0001;
          if (body_left == 16'h0000) put_packet_tail();
        end
      end
      MODE_REPLY: begin
        if (link_phase == LINK_REPLY) begin
          ackv = (item.reply_ack == AckGood) || (item.reply_ack == AckAlt);
          fat = (item.reply_status & fatal_bits) != 8'h00;
          busy = (item.reply_status & busy_bits) != 8'h00;
          if (pkt_cmd == CMD_INIT) ok = ackv && (item.reply_status == 8'h00);
          else if (pkt_cmd == CMD_PRINT) ok = ackv && !fat && !busy;
          else ok = ackv && !fat;
          link_phase = LINK_IDLE;
          r = '0;
          r.kind = KindVerdict;
          r.ok = ok;
          r.ack_valid = ackv;
          r.fatal = fat;
          r.busy = busy;
          r.status = item.reply_status;
          link_results_due.push_back(r);
        end
      end
      default: ;
    endcase
    if (link_results_due.size() > n_before) begin
      r = link_results_due.pop_back();
      r.last = 1'b1;
      link_results_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) compute_link_results(link_items_pending.pop_front());
      if (link_items_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        push <= 1'b1;
        mode_i <= link_items_pending[0].mode;
        command_i <= link_items_pending[0].command;
        payload_length_i <= link_items_pending[0].payload_length;
        before_feeds_i <= link_items_pending[0].before_feeds;
        after_feeds_i <= link_items_pending[0].after_feeds;
        density_i <= link_items_pending[0].density;
        data_byte_i <= link_items_pending[0].data_byte;
        reply_ack_i <= link_items_pending[0].reply_ack;
        reply_status_i <= link_items_pending[0].reply_status;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (results_seen == 150 || results_seen == 1500) hold_left = LongHold;
        if (link_results_due.size() == 0) begin
          $error("result transfer with nothing expected: kind %0h tx_byte %0h",
                 kind_o, tx_byte_o);
          mismatches++;
        end else begin
          want = link_results_due.pop_front();
          check_field("kind", 8'(want.kind), 8'(kind_o));
          check_field("tx_byte", want.tx_byte, tx_byte_o);
          check_field("last", 8'(want.last), 8'(last_o));
          check_field("ok", 8'(want.ok), 8'(ok_o));
          check_field("ack_valid", 8'(want.ack_valid), 8'(ack_valid_o));
          check_field("fatal", 8'(want.fatal), 8'(fatal_o));
          check_field("busy_res", 8'(want.busy), 8'(busy_res_o));
          check_field("status_byte", want.status, status_byte_o);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_results_done();
    do @(negedge clk_i);
    while (link_items_pending.size() != 0 || link_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgFatalMask) fatal_bits = val;
    else busy_bits = val;
    @(negedge clk_i);
  endtask

  task automatic add_traffic(input int unsigned target);
    int unsigned made, pick, stop_at;
    logic [2:0] cmd;
    logic [15:0] len;
    logic [7:0] ack, st;
    link_item_t it;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        it = make_item(MODE_START);
        case ($urandom_range(0, 3))
          0: it.mode = MODE_PAYLOAD;
          1: it.mode = MODE_REPLY;
          2: it.mode = MODE_UNUSED;
          default: it.command = $urandom_range(0, 1) ? CmdSpareA : CmdSpareB;
        endcase
        link_items_pending.push_back(it);
      end else begin
        cmd = 3'($urandom_range(0, 5));
        len = 16'($urandom);
        stop_at = 0;
        if (cmd == CMD_DATA) begin
          case ($urandom_range(0, 9))
            0: len = 16'($urandom_range(MaxPayload + 1, 65535));
            1: len = 16'h0000;
            default: len = 16'($urandom_range(1, 12));
          endcase
          if (32'(len) <= MaxPayload) begin
            stop_at = len;
            if ($urandom_range(0, 19) == 0 && len != 0) stop_at = $urandom_range(0, len - 1);
          end
        end
        it = start_pkt(cmd, len);
        if (cmd == CMD_PRINT && $urandom_range(0, 1) != 0) begin
          it.before_feeds = 8'($urandom_range(0, 16));
          it.after_feeds = 8'($urandom_range(0, 16));
          it.density = 8'($urandom_range(0, 128));
        end
        link_items_pending.push_back(it);
        made++;
        repeat (stop_at) link_items_pending.push_back(body_byte(8'($urandom)));
        made += stop_at;
        if (pick >= 12) begin
          case ($urandom_range(0, 3))
            0: ack = AckGood;
            1: ack = AckAlt;
            default: ack = 8'($urandom);
          endcase
          case ($urandom_range(0, 2))
            0: st = 8'h00;
            1: st = 8'(1 << $urandom_range(0, 7));
            default: st = 8'($urandom);
          endcase
          link_items_pending.push_back(printer_reply(ack, st));
          made++;
        end
      end
    end
  endtask

  initial begin
    link_item_t it;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    link_items_pending.push_back(start_pkt(CMD_INIT, 16'($urandom)));
    link_items_pending.push_back(printer_reply(AckGood, 8'h00));
    it = start_pkt(CMD_PRINT, 16'($urandom));
    it.before_feeds = 8'hFF;
    it.after_feeds = 8'hFF;
    it.density = 8'hFF;
    link_items_pending.push_back(it);
    link_items_pending.push_back(printer_reply(AckAlt, 8'h02));
    link_items_pending.push_back(start_pkt(CMD_DATA, 16'h0000));
    link_items_pending.push_back(printer_reply(8'h82, 8'hF1));
    link_items_pending.push_back(start_pkt(CMD_DATA, 16'(MaxPayload + 1)));
    link_items_pending.push_back(printer_reply(AckGood, 8'h00));
    link_items_pending.push_back(start_pkt(CMD_DATA, 16'h0002));
    link_items_pending.push_back(body_byte(8'h00));
    link_items_pending.push_back(body_byte(8'hFF));
    link_items_pending.push_back(printer_reply(AckGood, 8'hFF));
    link_items_pending.push_back(start_pkt(CMD_DATA_END, 16'($urandom)));
    link_items_pending.push_back(printer_reply(AckAlt, 8'h01));
    link_items_pending.push_back(start_pkt(CMD_INQUIRY, 16'($urandom)));
    link_items_pending.push_back(printer_reply(8'hFF, 8'h80));
    link_items_pending.push_back(start_pkt(CmdSpareA, 16'($urandom)));
    link_items_pending.push_back(start_pkt(CmdSpareB, 16'($urandom)));
    link_items_pending.push_back(body_byte(8'h5A));
    link_items_pending.push_back(make_item(MODE_UNUSED));
    link_items_pending.push_back(start_pkt(CMD_DATA, 16'h0003));
    link_items_pending.push_back(body_byte(8'hAA));
    link_items_pending.push_back(start_pkt(CMD_BREAK, 16'($urandom)));
    link_items_pending.push_back(printer_reply(8'h7F, 8'h00));
    wait_results_done();
    repeat (SettleCycles) @(posedge clk_i);

    for (int k = 0; k < 4; k++) begin
      case (k)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 87;
          write_reg(CfgFatalMask, 8'h00);
          write_reg(CfgBusyMask, 8'h00);
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 20;
          write_reg(CfgFatalMask, 8'hFF);
          write_reg(CfgBusyMask, 8'hFF);
        end
        2: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_reg(CfgFatalMask, 8'($urandom));
          write_reg(CfgBusyMask, 8'($urandom));
        end
        default: begin
          write_reg(CfgFatalMask, FatalMaskRst);
          write_reg(CfgBusyMask, 8'(1 << $urandom_range(0, 7)));
        end
      endcase
      add_traffic(55);
      wait_results_done();
      add_traffic(55);
      if (k == 2) begin
        link_items_pending.push_back(start_pkt(CMD_DATA, 16'(MaxPayload)));
        repeat (3) link_items_pending.push_back(body_byte(8'($urandom)));
        link_items_pending.push_back(start_pkt(CMD_INQUIRY, 16'($urandom)));
        link_items_pending.push_back(printer_reply(AckGood, 8'h00));
      end
      wait_results_done();
      repeat (SettleCycles) @(posedge clk_i);
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
